>>> design/hmas_pkg.sv
package hmas_pkg;

  // Default geometry
  localparam int CLASS_COUNT_DEF = 8;
  localparam int WORD_COUNT_DEF  = 256;

  // Field widths
  localparam int DATA_W  = 32;
  localparam int SEL_W   = 3;
  localparam int WIDX_W  = 8;
  localparam int DIST_W  = 14;
  localparam int POP_W   = 6;

  // Saturation ceiling of each distance accumulator
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Popcount masks
  localparam logic [31:0] M1  = 32'h5555_5555;
  localparam logic [31:0] M2  = 32'h3333_3333;
  localparam logic [31:0] M4  = 32'h0F0F_0F0F;
  localparam logic [31:0] H01 = 32'h0101_0101;

  // Command handed from front to back
  typedef struct packed {
    logic              load;
    logic              accum;
    logic              emit;
    logic [SEL_W-1:0]  cls;
    logic [WIDX_W-1:0] widx;
    logic [DATA_W-1:0] data;
  } hmas_cmd_t;

  // Count set bits of a 32-bit word
  function automatic logic [POP_W-1:0] popcount32(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] p;
    a = v - ((v >> 1) & M1);
    b = (a & M2) + ((a >> 2) & M2);
    c = (b + (b >> 4)) & M4;
    p = c * H01;
    return p[29:24];
  endfunction

endpackage

>>> design/hmas_front.sv
module hmas_front #(
  parameter int CLASS_COUNT = hmas_pkg::CLASS_COUNT_DEF,
  parameter int WORD_COUNT  = hmas_pkg::WORD_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_operation,
  input  logic [hmas_pkg::SEL_W-1:0]  in_class_sel,
  input  logic [hmas_pkg::WIDX_W-1:0] in_word_index,
  input  logic [hmas_pkg::DATA_W-1:0] in_data_word,
  input  logic                      in_last_word,
  output logic                      cmd_valid,
  input  logic                      cmd_ready,
  output hmas_pkg::hmas_cmd_t       cmd
);
  import hmas_pkg::*;

  logic      fr_valid_r;
  logic      fr_valid_nxt;
  hmas_cmd_t fr_cmd_r;
  hmas_cmd_t cls_cmd;
  logic      is_query;
  logic      cls_ok;
  logic      widx_ok;
  logic      cmd_live;
  logic      in_beat;

  // Classify the incoming beat
  always_comb begin
    is_query      = (in_operation == OP_QUERY);
    cls_ok        = 32'(in_class_sel) < CLASS_COUNT;
    widx_ok       = 32'(in_word_index) < WORD_COUNT;
    cls_cmd.load  = !is_query && cls_ok && widx_ok;
    cls_cmd.accum = is_query && widx_ok;
    cls_cmd.emit  = is_query && in_last_word;
    cls_cmd.cls   = in_class_sel;
    cls_cmd.widx  = in_word_index;
    cls_cmd.data  = in_data_word;
    cmd_live      = cls_cmd.load || cls_cmd.accum || cls_cmd.emit;
  end

  assign in_ready = !fr_valid_r || cmd_ready;
  assign in_beat  = in_valid && in_ready;

  // Hold a command until the queue takes it; drop beats with no effect
  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (fr_valid_r && cmd_ready) begin
      fr_valid_nxt = 1'b0;
    end
    if (in_beat) begin
      fr_valid_nxt = cmd_live;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      fr_cmd_r <= cls_cmd;
    end
  end

  assign cmd_valid = fr_valid_r;
  assign cmd       = fr_cmd_r;

endmodule

>>> design/hmas_queue.sv
module hmas_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  hmas_pkg::hmas_cmd_t push_cmd,
  output logic                pop_valid,
  input  logic                pop_ready,
  output hmas_pkg::hmas_cmd_t pop_cmd
);
  import hmas_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  hmas_cmd_t       q_mem [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CNTW-1:0] count_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count_r != CNTW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = q_mem[rd_ptr_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!do_push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> design/hmas_back.sv
module hmas_back #(
  parameter int CLASS_COUNT = hmas_pkg::CLASS_COUNT_DEF,
  parameter int WORD_COUNT  = hmas_pkg::WORD_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  hmas_pkg::hmas_cmd_t         cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hmas_pkg::SEL_W-1:0]  out_class_index,
  output logic [hmas_pkg::DIST_W-1:0] out_distance,
  output logic [hmas_pkg::SEL_W-1:0]  out_best_class,
  output logic                        out_final_res
);
  import hmas_pkg::*;

  localparam int CW    = $clog2(CLASS_COUNT);
  localparam int WW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int DEPTH = CLASS_COUNT * WORD_COUNT;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    B_IDLE     = 5'b00001,
    B_ACC      = 5'b00010,
    B_DRAIN    = 5'b00100,
    B_EMIT_RD  = 5'b01000,
    B_EMIT_OUT = 5'b10000
  } back_state_t;

  back_state_t state_r;
  back_state_t state_nxt;

  // Class vectors and distance accumulators
  logic [DATA_W-1:0] cmem [DEPTH];
  logic [DIST_W-1:0] acc_mem [CLASS_COUNT];
  logic [CLASS_COUNT-1:0] acc_vld_r;

  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic [DATA_W-1:0] q_data_r;
  logic [WW-1:0]     q_widx_r;
  logic              emit_pend_r;
  logic              emit_pend_nxt;

  // Pipeline: read, popcount, accumulate
  logic              p1_r;
  logic              p2_r;
  logic [CW-1:0]     c1_r;
  logic [CW-1:0]     c2_r;
  logic [DATA_W-1:0] mem_rd_r;
  logic [DIST_W-1:0] acc_rd_r;
  logic              vld_rd_r;
  logic [POP_W-1:0]  pop_r;
  logic [DIST_W-1:0] acc2_r;
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] sat_sum;

  // Best-class tracking
  logic [CW-1:0]     best_r;
  logic [DIST_W-1:0] best_dist_r;
  logic [CW-1:0]     best_nxt;
  logic [DIST_W-1:0] best_dist_nxt;
  logic [DIST_W-1:0] emit_dist;

  // Output register
  logic              out_valid_r;
  logic [SEL_W-1:0]  out_cls_r;
  logic [DIST_W-1:0] out_dist_r;
  logic [SEL_W-1:0]  out_best_r;
  logic              out_final_r;

  logic [CW+SEL_W-1:0]  cls_ext;
  logic [WW+WIDX_W-1:0] widx_ext;
  logic [CW+SEL_W-1:0]  cnt_ext;
  logic [CW+SEL_W-1:0]  best_ext;
  logic [CW-1:0]        cmd_cls;
  logic [WW-1:0]        cmd_widx;
  logic [AW-1:0]        ld_addr;
  logic [AW-1:0]        rd_addr;
  logic                 cnt_last;
  logic                 out_free;
  logic                 take_cmd;
  logic                 do_load;
  logic                 issue;
  logic                 emit_rd;
  logic                 emit_go;

  // Resize command fields to the storage geometry
  assign cls_ext  = {{CW{1'b0}}, cmd.cls};
  assign widx_ext = {{WW{1'b0}}, cmd.widx};
  assign cmd_cls  = cls_ext[CW-1:0];
  assign cmd_widx = widx_ext[WW-1:0];
  assign ld_addr  = AW'(int'(cmd_cls) * WORD_COUNT + int'(cmd_widx));
  assign rd_addr  = AW'(int'(cnt_r) * WORD_COUNT + int'(q_widx_r));

  assign cnt_last  = (cnt_r == CW'(CLASS_COUNT - 1));
  assign out_free  = !out_valid_r || out_ready;
  assign cmd_ready = (state_r == B_IDLE);
  assign take_cmd  = cmd_valid && cmd_ready;
  assign do_load   = take_cmd && cmd.load;
  assign issue     = (state_r == B_ACC);
  assign emit_rd   = (state_r == B_EMIT_RD);
  assign emit_go   = (state_r == B_EMIT_OUT) && out_free;

  // Saturating accumulate
  assign sum     = {1'b0, acc2_r} + (DIST_W + 1)'(pop_r);
  assign sat_sum = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

  // Running minimum, lowest index wins ties
  always_comb begin
    emit_dist     = vld_rd_r ? acc_rd_r : '0;
    best_nxt      = best_r;
    best_dist_nxt = best_dist_r;
    if (cnt_r == '0 || emit_dist < best_dist_r) begin
      best_nxt      = cnt_r;
      best_dist_nxt = emit_dist;
    end
  end

  assign cnt_ext  = {{SEL_W{1'b0}}, cnt_r};
  assign best_ext = {{SEL_W{1'b0}}, best_nxt};

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    emit_pend_nxt = emit_pend_r;
    case (state_r)
      B_IDLE: begin
        if (take_cmd) begin
          cnt_nxt       = '0;
          emit_pend_nxt = cmd.emit;
          if (cmd.accum) begin
            state_nxt = B_ACC;
          end else if (cmd.emit) begin
            state_nxt = B_EMIT_RD;
          end
        end
      end
      B_ACC: begin
        if (cnt_last) begin
          state_nxt = B_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      B_DRAIN: begin
        if (!p1_r && !p2_r) begin
          cnt_nxt   = '0;
          state_nxt = emit_pend_r ? B_EMIT_RD : B_IDLE;
        end
      end
      B_EMIT_RD: begin
        state_nxt = B_EMIT_OUT;
      end
      B_EMIT_OUT: begin
        if (emit_go) begin
          if (cnt_last) begin
            state_nxt = B_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = B_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      p1_r        <= 1'b0;
      p2_r        <= 1'b0;
      acc_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p1_r    <= issue;
      p2_r    <= p1_r;
      if (p2_r) begin
        acc_vld_r[c2_r] <= 1'b1;
      end
      if (emit_go) begin
        acc_vld_r[cnt_r] <= 1'b0;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Counters and query latch
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    emit_pend_r <= emit_pend_nxt;
    if (take_cmd) begin
      q_data_r <= cmd.data;
      q_widx_r <= cmd_widx;
    end
    if (emit_go) begin
      best_r      <= best_nxt;
      best_dist_r <= best_dist_nxt;
    end
  end

  // Class memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_load) begin
      cmem[ld_addr] <= cmd.data;
    end
    if (issue) begin
      mem_rd_r <= cmem[rd_addr];
    end
  end

  // Accumulator memory: write from last stage, registered read
  always_ff @(posedge clk) begin
    if (p2_r) begin
      acc_mem[c2_r] <= sat_sum;
    end
    if (issue || emit_rd) begin
      acc_rd_r <= acc_mem[cnt_r];
      vld_rd_r <= acc_vld_r[cnt_r];
    end
  end

  // Advance the pipeline payload
  always_ff @(posedge clk) begin
    c1_r   <= cnt_r;
    c2_r   <= c1_r;
    pop_r  <= popcount32(q_data_r ^ mem_rd_r);
    acc2_r <= vld_rd_r ? acc_rd_r : '0;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_cls_r   <= cnt_ext[SEL_W-1:0];
      out_dist_r  <= emit_dist;
      out_best_r  <= cnt_last ? best_ext[SEL_W-1:0] : '0;
      out_final_r <= cnt_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_class_index = out_cls_r;
  assign out_distance    = out_dist_r;
  assign out_best_class  = out_best_r;
  assign out_final_res   = out_final_r;

endmodule

>>> design/hamming_associative_search.sv
// Channel | Handshake             | Beat contents
// in_     | in_valid / in_ready   | operation, class_sel, word_index, data_word, last_word
// out_    | out_valid / out_ready | class_index, distance, best_class, final_res
//
// A load word is written to class memory as the back end takes it; a query word is
// taken, then run class by class through the shared popcount/accumulate pipe,
// and the pipe is drained.
// A last query word then emits CLASS_COUNT results, each after an accumulator read.
// Reset clears the accumulators at once through per-class valid bits; class
// memory is not initialized. A 4-entry queue decouples intake from the back end,
// so input stalls only when the queue is full and output stalls only the back end.
module hamming_associative_search #(
  parameter int CLASS_COUNT = hmas_pkg::CLASS_COUNT_DEF,
  parameter int WORD_COUNT  = hmas_pkg::WORD_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic [hmas_pkg::SEL_W-1:0]  in_class_sel,
  input  logic [hmas_pkg::WIDX_W-1:0] in_word_index,
  input  logic [hmas_pkg::DATA_W-1:0] in_data_word,
  input  logic                        in_last_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hmas_pkg::SEL_W-1:0]  out_class_index,
  output logic [hmas_pkg::DIST_W-1:0] out_distance,
  output logic [hmas_pkg::SEL_W-1:0]  out_best_class,
  output logic                        out_final_res
);
  import hmas_pkg::*;

  hmas_cmd_t fr_cmd;
  hmas_cmd_t bk_cmd;
  logic      fr_valid;
  logic      fr_ready;
  logic      bk_valid;
  logic      bk_ready;

  hmas_front #(
    .CLASS_COUNT(CLASS_COUNT),
    .WORD_COUNT (WORD_COUNT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_class_sel (in_class_sel),
    .in_word_index(in_word_index),
    .in_data_word (in_data_word),
    .in_last_word (in_last_word),
    .cmd_valid    (fr_valid),
    .cmd_ready    (fr_ready),
    .cmd          (fr_cmd)
  );

  hmas_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(fr_valid),
    .push_ready(fr_ready),
    .push_cmd  (fr_cmd),
    .pop_valid (bk_valid),
    .pop_ready (bk_ready),
    .pop_cmd   (bk_cmd)
  );

  hmas_back #(
    .CLASS_COUNT(CLASS_COUNT),
    .WORD_COUNT (WORD_COUNT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (bk_valid),
    .cmd_ready      (bk_ready),
    .cmd            (bk_cmd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_class_index(out_class_index),
    .out_distance   (out_distance),
    .out_best_class (out_best_class),
    .out_final_res  (out_final_res)
  );

endmodule

>>> design/hmas_checker.sv
module hmas_checker #(
  parameter int CLASS_COUNT = hmas_pkg::CLASS_COUNT_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [hmas_pkg::SEL_W-1:0]  out_class_index,
  input logic [hmas_pkg::DIST_W-1:0] out_distance,
  input logic [hmas_pkg::SEL_W-1:0]  out_best_class,
  input logic                        out_final_res
);
  import hmas_pkg::*;

  localparam logic [SEL_W-1:0] LAST_IDX = SEL_W'((CLASS_COUNT - 1) % 8);

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_class_index) &&
      $stable(out_distance) && $stable(out_best_class) && $stable(out_final_res))
    else $error("stalled result changed");

  // Best class shown only on the final result
  a_best_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_res |-> out_best_class == '0)
    else $error("best class on non-final result");

  // Final result belongs to the last class
  a_final_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_res |-> out_class_index == LAST_IDX)
    else $error("final result on wrong class");

endmodule

bind hamming_associative_search hmas_checker #(
  .CLASS_COUNT(CLASS_COUNT)
) u_hmas_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_class_index(out_class_index),
  .out_distance   (out_distance),
  .out_best_class (out_best_class),
  .out_final_res  (out_final_res)
);

>>> dv/tb_top.sv
module tb_top;
  import hmas_pkg::*;

  localparam int CLS_N  = CLASS_COUNT_DEF;
  localparam int WORDS  = WORD_COUNT_DEF;
  localparam int SETTLE = 40;
  localparam int HOLD_CYCLES = 400;

  typedef logic [0:CLS_N-1][DIST_W-1:0] dist_vec_t;

  typedef struct packed {
    logic              op;
    logic [SEL_W-1:0]  cls;
    logic [WIDX_W-1:0] widx;
    logic [DATA_W-1:0] data;
    logic              last;
  } beat_t;

  typedef struct packed {
    logic [SEL_W-1:0]  class_index;
    logic [DIST_W-1:0] distance;
    logic [SEL_W-1:0]  best_class;
    logic              final_res;
  } dist_result_t;

  typedef struct {
    beat_t            beat;
    bit               typed;
    logic [SEL_W-1:0] best;
    dist_vec_t        exp_dist;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_operation;
  logic [SEL_W-1:0]  in_class_sel;
  logic [WIDX_W-1:0] in_word_index;
  logic [DATA_W-1:0] in_data_word;
  logic              in_last_word;
  logic              out_valid;
  logic              out_ready;
  logic [SEL_W-1:0]  out_class_index;
  logic [DIST_W-1:0] out_distance;
  logic [SEL_W-1:0]  out_best_class;
  logic              out_final_res;

  // Mirror of the block state
  logic [DATA_W-1:0] class_words [CLS_N][WORDS];
  logic [DIST_W-1:0] dist_acc [CLS_N];

  dist_result_t pending_results[$];
  dir_row_t     dir_rows[$];
  int           full_words[$];
  bit           word_full [WORDS];

  bit   mismatch_seen;
  int   src_idle_pct;
  int   sink_stall_pct;
  bit   hold_active;
  event hold_off_ev;

  hamming_associative_search DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_class_sel    (in_class_sel),
    .in_word_index   (in_word_index),
    .in_data_word    (in_data_word),
    .in_last_word    (in_last_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_class_index (out_class_index),
    .out_distance    (out_distance),
    .out_best_class  (out_best_class),
    .out_final_res   (out_final_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  // Apply one accepted beat to the mirror; return the distances it releases
  function automatic int score_beat(input beat_t b, output dist_result_t res [CLS_N]);
    logic [DIST_W:0] sum;
    int best;
    for (int c = 0; c < CLS_N; c++) res[c] = '0;
    if (b.op == OP_LOAD) begin
      if (int'(b.cls) < CLS_N && int'(b.widx) < WORDS) class_words[b.cls][b.widx] = b.data;
      return 0;
    end
    // accumulate with saturation
    if (int'(b.widx) < WORDS) begin
      for (int c = 0; c < CLS_N; c++) begin
        sum = (DIST_W + 1)'(dist_acc[c]) +
              (DIST_W + 1)'($countones(b.data ^ class_words[c][b.widx]));
        dist_acc[c] = (sum > DIST_MAX) ? DIST_MAX : sum[DIST_W-1:0];
      end
    end
    if (!b.last) return 0;
    // lowest index wins ties
    best = 0;
    for (int c = 1; c < CLS_N; c++) begin
      if (dist_acc[c] < dist_acc[best]) best = c;
    end
    for (int c = 0; c < CLS_N; c++) begin
      res[c].class_index = c[SEL_W-1:0];
      res[c].distance    = dist_acc[c];
      res[c].best_class  = (c == CLS_N - 1) ? best[SEL_W-1:0] : '0;
      res[c].final_res   = (c == CLS_N - 1);
      dist_acc[c] = '0;
    end
    return CLS_N;
  endfunction

  function automatic beat_t pack_beat(input logic op, input int cls, input int widx,
                                      input logic [DATA_W-1:0] data, input logic last);
    beat_t b;
    b.op   = op;
    b.cls  = cls[SEL_W-1:0];
    b.widx = widx[WIDX_W-1:0];
    b.data = data;
    b.last = last;
    return b;
  endfunction

  // Mix of extremes, near-misses of stored words and plain random words
  function automatic logic [DATA_W-1:0] pick_data(input int w);
    int k;
    k = $urandom_range(0, 7);
    case (k)
      0: return '0;
      1: return '1;
      2, 3: return class_words[$urandom_range(0, CLS_N - 1)][w] ^ (32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // Drive one beat, hold it until accepted, then queue what it releases
  task automatic send_beat(input beat_t b, input bit typed = 1'b0,
                           input logic [SEL_W-1:0] typed_best = '0,
                           input dist_vec_t typed_dist = '0);
    dist_result_t res [CLS_N];
    int n;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= b.op;
    in_class_sel  <= b.cls;
    in_word_index <= b.widx;
    in_data_word  <= b.data;
    in_last_word  <= b.last;
    do @(posedge clk); while (!in_ready);
    n = score_beat(b, res);
    if (typed && n == CLS_N) begin
      for (int c = 0; c < CLS_N; c++) res[c].distance = typed_dist[c];
      res[CLS_N-1].best_class = typed_best;
    end
    for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
    @(negedge clk);
  endtask

  // Drop valid and wait for every queued distance, bounded
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic mark_full(input int w);
    if (!word_full[w]) begin
      word_full[w] = 1'b1;
      full_words.push_back(w);
    end
  endtask

  task automatic add_row(input logic op, input int cls, input int widx,
                         input logic [DATA_W-1:0] data, input logic last,
                         input bit typed = 1'b0, input int best = 0,
                         input dist_vec_t exp_dist = '0);
    dir_row_t r;
    r.beat     = pack_beat(op, cls, widx, data, last);
    r.typed    = typed;
    r.best     = best[SEL_W-1:0];
    r.exp_dist = exp_dist;
    dir_rows.push_back(r);
  endtask

  // Class-word bursts, stray loads and query runs over fully loaded positions
  task automatic random_traffic(input int n_beats);
    int sent;
    int kind;
    int len;
    int w;
    sent = 0;
    while (sent < n_beats) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        w = $urandom_range(0, WORDS - 1);
        for (int c = 0; c < CLS_N; c++) begin
          send_beat(pack_beat(OP_LOAD, c, w, pick_data(w), 1'($urandom_range(0, 1))));
          sent++;
        end
        mark_full(w);
      end else if (kind == 2) begin
        if ($urandom_range(0, 1)) w = full_words[$urandom_range(0, full_words.size() - 1)];
        else w = $urandom_range(0, WORDS - 1);
        send_beat(pack_beat(OP_LOAD, $urandom_range(0, CLS_N - 1), w, $urandom,
                            1'($urandom_range(0, 1))));
        sent++;
      end else begin
        // query run; an occasional run without its last mark carries over
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          w = full_words[$urandom_range(0, full_words.size() - 1)];
          send_beat(pack_beat(OP_QUERY, $urandom_range(0, CLS_N - 1), w, pick_data(w),
                              (i == len - 1) && ($urandom_range(0, 9) != 0)));
          sent++;
        end
      end
    end
  endtask

  // Long receiver hold-off, counted here
  initial begin
    hold_active = 1'b0;
    forever begin
      @(hold_off_ev);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active = 1'b0;
    end
  end

  // Receiver ready
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= !hold_active && ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    dist_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: class %0d dist %0d best %0d final %0b", $time,
                 out_class_index, out_distance, out_best_class, out_final_res);
        mismatch_seen = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (out_class_index !== want.class_index || out_distance !== want.distance ||
            out_best_class !== want.best_class || out_final_res !== want.final_res) begin
          $display("%0t: result mismatch: expected class %0d dist %0d best %0d final %0b, got class %0d dist %0d best %0d final %0b",
                   $time, want.class_index, want.distance, want.best_class,
                   want.final_res, out_class_index, out_distance, out_best_class,
                   out_final_res);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  initial begin
    mismatch_seen  = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    for (int c = 0; c < CLS_N; c++) begin
      dist_acc[c] = '0;
      for (int i = 0; i < WORDS; i++) class_words[c][i] = '0;
    end
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_operation  <= OP_LOAD;
    in_class_sel  <= '0;
    in_word_index <= '0;
    in_data_word  <= '0;
    in_last_word  <= 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: load positions 0 and 255, last mark on a load is ignored
    add_row(OP_LOAD, 0, 0, 32'h0000_0000, 1'b0);
    add_row(OP_LOAD, 1, 0, 32'hFFFF_FFFF, 1'b1);
    add_row(OP_LOAD, 2, 0, 32'h0000_FFFF, 1'b0);
    add_row(OP_LOAD, 3, 0, 32'hFFFF_0000, 1'b0);
    add_row(OP_LOAD, 4, 0, 32'h0F0F_0F0F, 1'b0);
    add_row(OP_LOAD, 5, 0, 32'hF0F0_F0F0, 1'b0);
    add_row(OP_LOAD, 6, 0, 32'h0000_0001, 1'b0);
    add_row(OP_LOAD, 7, 0, 32'h8000_0000, 1'b0);
    add_row(OP_LOAD, 0, 255, 32'hFFFF_FFFF, 1'b0);
    add_row(OP_LOAD, 1, 255, 32'h0000_0000, 1'b0);
    add_row(OP_LOAD, 2, 255, 32'hAAAA_AAAA, 1'b0);
    add_row(OP_LOAD, 3, 255, 32'h5555_5555, 1'b1);
    add_row(OP_LOAD, 4, 255, 32'hFFFF_FFFF, 1'b0);
    add_row(OP_LOAD, 5, 255, 32'h0000_0000, 1'b0);
    add_row(OP_LOAD, 6, 255, 32'h1234_5678, 1'b0);
    add_row(OP_LOAD, 7, 255, 32'hFFFF_FFFE, 1'b0);
    // single-word queries with known distances
    add_row(OP_QUERY, 0, 0, 32'h0000_0000, 1'b1, 1'b1, 0,
            {14'd0, 14'd32, 14'd16, 14'd16, 14'd16, 14'd16, 14'd1, 14'd1});
    add_row(OP_QUERY, 7, 0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1,
            {14'd32, 14'd0, 14'd16, 14'd16, 14'd16, 14'd16, 14'd31, 14'd31});
    // two-word query, every class ties at 32
    add_row(OP_QUERY, 5, 255, 32'h0000_0000, 1'b0);
    add_row(OP_QUERY, 2, 255, 32'hFFFF_FFFF, 1'b1, 1'b1, 0,
            {14'd32, 14'd32, 14'd32, 14'd32, 14'd32, 14'd32, 14'd32, 14'd32});
    add_row(OP_QUERY, 3, 0, 32'h0000_FFFF, 1'b1, 1'b1, 2,
            {14'd16, 14'd16, 14'd0, 14'd32, 14'd16, 14'd16, 14'd15, 14'd17});
    // tie between classes 6 and 7 resolves to 6
    add_row(OP_QUERY, 6, 0, 32'h8000_0001, 1'b1, 1'b1, 6,
            {14'd2, 14'd30, 14'd16, 14'd16, 14'd16, 14'd16, 14'd1, 14'd1});
    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].best,
                                    dir_rows[i].exp_dist);
    mark_full(0);
    mark_full(255);
    wait_drained();

    // Random traffic over the idling phases
    src_idle_pct = 0;  sink_stall_pct = 0;
    random_traffic(85);
    src_idle_pct = 49; sink_stall_pct = 0;
    random_traffic(85);
    src_idle_pct = 0;  sink_stall_pct = 49;
    random_traffic(85);
    src_idle_pct = 25; sink_stall_pct = 25;
    random_traffic(85);

    // Hold off the receiver while beats keep coming, then pause until drained
    src_idle_pct = 0;  sink_stall_pct = 0;
    ->hold_off_ev;
    random_traffic(40);
    wait_drained();

    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      mismatch_seen = 1'b1;
    end
    if (!mismatch_seen) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
design/hmas_pkg.sv
design/hmas_front.sv
design/hmas_queue.sv
design/hmas_back.sv
design/hamming_associative_search.sv
design/hmas_checker.sv
dv/tb_top.sv
